@@ rtl/rgba_overlay_yuv420_blend_defines.svh @@
// Assertion macros for the overlay blend block.
`ifndef RGBA_OVERLAY_YUV420_BLEND_DEFINES_SVH
`define RGBA_OVERLAY_YUV420_BLEND_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, ante, cons)
`endif

`endif

@@ rtl/rgbaovl_pkg.sv @@
package rgbaovl_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = COL_W + 1;
   localparam int STORE_W     = 25;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1920);
   localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(4);
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       alpha;
      logic [7:0]       bg_luma;
      logic [7:0]       bg_cb;
      logic [7:0]       bg_cr;
      logic             col_odd;
      logic             odd_row;
      logic             first_col;
      logic             last_col;
      logic [IDX_W-1:0] idx;
   } s1_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] alpha;
      logic [7:0] bg_luma;
      logic [7:0] bg_cb;
      logic [7:0] bg_cr;
      logic [7:0] cb;
      logic [7:0] cr;
      logic [7:0] chroma_alpha;
      logic       chroma_valid;
      logic       any_alpha;
   } s2_type;

   typedef struct packed {
      logic [7:0] luma_out;
      logic       luma_write;
      logic       chroma_valid;
      logic [7:0] cb_out;
      logic [7:0] cr_out;
      logic       chroma_write;
   } rsp_type;

   // floor(n / 255), exact for n up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] t;
      t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   function automatic logic [7:0] blend(input logic [7:0] fg, input logic [7:0] a,
                                        input logic [7:0] bg);
      logic [15:0] p;
      p = ({8'd0, fg} * {8'd0, a}) + ({8'd0, bg} * {8'd0, 8'd255 - a});
      return div255(p);
   endfunction

   function automatic logic [7:0] tap121(input logic [7:0] l, input logic [7:0] c,
                                         input logic [7:0] r);
      logic [9:0] s;
      s = {2'b00, l} + {1'b0, c, 1'b0} + {2'b00, r};
      return s[9:2];
   endfunction

   function automatic logic [7:0] avg2(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[8:1];
   endfunction

endpackage

@@ rtl/rgba_overlay_yuv420_blend.sv @@
// RGBA overlay blended onto a YUV 4:2:0 background, one pixel per request.
// Request channel (req_*): overlay RGBA, background luma and, on odd-row
// odd-column pixels, the background Cb/Cr of the 2x2 block. start_of_frame
// marks row 0 column 0. Response channel (rsp_*): one result per request
// with blended luma and, when chroma_valid is set, the blended block chroma.
// csr_wr_en/csr_wr_data set the row width; write it only while idle.
// One request is taken every cycle unless req_stall is high. The pipeline is
// input register, conversion/filter stage, then the blend multipliers feeding
// the response register. The even row's filtered chroma sits in a 2048 x 25
// line store, read at acceptance and written when an odd-column even-row
// pixel leaves the first stage.
// Reset empties the pipeline, clears row position and sets width to 1920;
// the line store is not cleared.
// A stalled response holds; stages behind it keep filling, and req_stall
// rises only once all three stages are full.
`include "rgba_overlay_yuv420_blend_defines.svh"

module rgba_overlay_yuv420_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rgbaovl_pkg::WIDTH_W-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_red,
   input  logic [7:0]                     req_green,
   input  logic [7:0]                     req_blue,
   input  logic [7:0]                     req_alpha,
   input  logic [7:0]                     req_bg_luma,
   input  logic [7:0]                     req_bg_cb,
   input  logic [7:0]                     req_bg_cr,
   input  logic                           req_start_of_frame,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_luma_out,
   output logic                           rsp_luma_write,
   output logic                           rsp_chroma_valid,
   output logic [7:0]                     rsp_cb_out,
   output logic [7:0]                     rsp_cr_out,
   output logic                           rsp_chroma_write
);
   import rgbaovl_pkg::*;

   logic [WIDTH_W-1:0] width_ff;
   logic [WIDTH_W-1:0] width_in;
   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic               odd_ff;
   logic               odd_in;

   logic               s1_valid_ff;
   s1_type             s1_ff;
   s1_type             s1_in;
   logic               s2_valid_ff;
   s2_type             s2_ff;
   s2_type             s2_in;
   logic               out_valid_ff;
   rsp_type            out_ff;
   rsp_type            out_in;

   logic [23:0]        win0_ff;
   logic [23:0]        win1_ff;
   logic [STORE_W-1:0] store_mem [STORE_DEPTH];
   logic [STORE_W-1:0] rd_ff;

   logic               out_en;
   logic               s2_en;
   logic               s1_en;
   logic               accept;

   logic [WIDTH_W-1:0] c0;
   logic [WIDTH_W-1:0] cur_col;
   logic [WIDTH_W-1:0] nxt_col;
   logic               o0;
   logic               wrap0;
   logic               wrap1;
   logic               cur_odd;

   logic [15:0]        rr;
   logic [15:0]        gg;
   logic [15:0]        bb;
   logic [15:0]        y_sum;
   logic [15:0]        cb_sum;
   logic [15:0]        cr_sum;
   logic [23:0]        cur_px;
   logic [23:0]        left_px;
   logic [23:0]        right_px;
   logic [STORE_W-1:0] filt;
   logic               store_wr;

   // Bubbles collapse: a stage moves when the one ahead is empty or moving.
   assign out_en    = !out_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;

   // Effective width: even, clamped to the line store range.
   always_comb begin
      width_in = width_ff;
      if (csr_wr_en) begin
         width_in = csr_wr_data & ~WIDTH_W'(1);
         if (width_in < WIDTH_MIN) begin
            width_in = WIDTH_MIN;
         end else if (width_in > WIDTH_MAX) begin
            width_in = WIDTH_MAX;
         end
      end
   end

   // Row position of the incoming pixel.
   always_comb begin
      c0      = req_start_of_frame ? '0 : {1'b0, col_ff};
      o0      = req_start_of_frame ? 1'b0 : odd_ff;
      wrap0   = (c0 >= width_ff);
      cur_col = wrap0 ? '0 : c0;
      cur_odd = o0 ^ wrap0;
      nxt_col = cur_col + WIDTH_W'(1);
      wrap1   = (nxt_col >= width_ff);
      col_in  = wrap1 ? '0 : nxt_col[COL_W-1:0];
      odd_in  = cur_odd ^ wrap1;

      s1_in.red       = req_red;
      s1_in.green     = req_green;
      s1_in.blue      = req_blue;
      s1_in.alpha     = req_alpha;
      s1_in.bg_luma   = req_bg_luma;
      s1_in.bg_cb     = req_bg_cb;
      s1_in.bg_cr     = req_bg_cr;
      s1_in.col_odd   = cur_col[0];
      s1_in.odd_row   = cur_odd;
      s1_in.first_col = (cur_col == WIDTH_W'(1));
      s1_in.last_col  = (nxt_col == width_ff);
      s1_in.idx       = cur_col[COL_W-1:1];
   end

   // Conversion, 1-2-1 filter and row average.
   always_comb begin
      rr     = {8'd0, s1_ff.red};
      gg     = {8'd0, s1_ff.green};
      bb     = {8'd0, s1_ff.blue};
      y_sum  = rr * 16'd66 + gg * 16'd129 + bb * 16'd25 + 16'd128;
      cb_sum = bb * 16'd112 + 16'd32896 - rr * 16'd38 - gg * 16'd74;
      cr_sum = rr * 16'd112 + 16'd32896 - gg * 16'd94 - bb * 16'd18;
      cur_px = {s1_ff.alpha, cr_sum[15:8], cb_sum[15:8]};

      left_px  = s1_ff.first_col ? win0_ff : win1_ff;
      right_px = s1_ff.last_col ? win0_ff : cur_px;
      filt[7:0]   = tap121(left_px[7:0], win0_ff[7:0], right_px[7:0]);
      filt[15:8]  = tap121(left_px[15:8], win0_ff[15:8], right_px[15:8]);
      filt[23:16] = tap121(left_px[23:16], win0_ff[23:16], right_px[23:16]);
      filt[24]    = |(left_px[23:16] | win0_ff[23:16] | right_px[23:16]);

      store_wr = s1_valid_ff && s2_en && s1_ff.col_odd && !s1_ff.odd_row;

      s2_in.luma         = y_sum[15:8] + 8'd16;
      s2_in.alpha        = s1_ff.alpha;
      s2_in.bg_luma      = s1_ff.bg_luma;
      s2_in.bg_cb        = s1_ff.bg_cb;
      s2_in.bg_cr        = s1_ff.bg_cr;
      s2_in.cb           = avg2(rd_ff[7:0], filt[7:0]);
      s2_in.cr           = avg2(rd_ff[15:8], filt[15:8]);
      s2_in.chroma_alpha = avg2(rd_ff[23:16], filt[23:16]);
      s2_in.chroma_valid = s1_ff.col_odd && s1_ff.odd_row;
      s2_in.any_alpha    = rd_ff[24] || filt[24];
   end

   // Blend and result.
   always_comb begin
      out_in              = '0;
      out_in.luma_out     = blend(s2_ff.luma, s2_ff.alpha, s2_ff.bg_luma);
      out_in.luma_write   = (s2_ff.alpha != 8'd0);
      out_in.chroma_valid = s2_ff.chroma_valid;
      if (s2_ff.chroma_valid) begin
         out_in.chroma_write = s2_ff.any_alpha;
         if (s2_ff.any_alpha) begin
            out_in.cb_out = blend(s2_ff.cb, s2_ff.chroma_alpha, s2_ff.bg_cb);
            out_in.cr_out = blend(s2_ff.cr, s2_ff.chroma_alpha, s2_ff.bg_cr);
         end else begin
            out_in.cb_out = s2_ff.bg_cb;
            out_in.cr_out = s2_ff.bg_cr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         col_ff       <= '0;
         odd_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         win0_ff      <= '0;
         win1_ff      <= '0;
      end else begin
         width_ff <= width_in;
         if (accept) begin
            col_ff <= col_in;
            odd_ff <= odd_in;
         end
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s2_valid_ff;
         end
         // advance the pixel window as each pixel leaves the first stage
         if (s1_valid_ff && s2_en) begin
            win1_ff <= win0_ff;
            win0_ff <= cur_px;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s2_en) begin
         s2_ff <= s2_in;
      end
      if (out_en) begin
         out_ff <= out_in;
      end
   end

   // Line store: even rows write, odd rows read at acceptance.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[s1_ff.idx] <= filt;
      end
      if (accept) begin
         rd_ff <= store_mem[cur_col[COL_W-1:1]];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma_out     = out_ff.luma_out;
   assign rsp_luma_write   = out_ff.luma_write;
   assign rsp_chroma_valid = out_ff.chroma_valid;
   assign rsp_cb_out       = out_ff.cb_out;
   assign rsp_cr_out       = out_ff.cr_out;
   assign rsp_chroma_write = out_ff.chroma_write;

   `ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall,
                 s1_valid_ff && s2_valid_ff && out_valid_ff && rsp_stall)
   `ASSERT_IMPLY(a_chroma_write_in_block, clock, reset, rsp_valid && rsp_chroma_write,
                 rsp_chroma_valid)
   `ASSERT_IMPLY(a_no_chroma_off_block, clock, reset, rsp_valid && !rsp_chroma_valid,
                 rsp_cb_out == 8'd0 && rsp_cr_out == 8'd0)
   `ASSERT_NEXT(a_empty_after_reset, clock, reset,
                !rsp_valid && !s1_valid_ff && !s2_valid_ff)

endmodule

@@ sim/tb_rgba_overlay_yuv420_blend.sv @@
module tb_rgba_overlay_yuv420_blend;
   import rgbaovl_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] bg_luma;
      logic [7:0] bg_cb;
      logic [7:0] bg_cr;
      logic       sof;
   } pixel_type;

   typedef enum int {
      ALPHA_CLEAR,
      ALPHA_OPAQUE,
      ALPHA_SPARSE,
      ALPHA_ANY
   } alpha_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               csr_wr_en   = 1'b0;
   logic [WIDTH_W-1:0] csr_wr_data = '0;

   logic      req_valid = 1'b0;
   logic      req_stall;
   pixel_type cur_px    = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_luma_out;
   logic       rsp_luma_write;
   logic       rsp_chroma_valid;
   logic [7:0] rsp_cb_out;
   logic [7:0] rsp_cr_out;
   logic       rsp_chroma_write;

   // Predicted block state
   logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
   int                 col_pos   = 0;
   logic               row_odd   = 1'b0;
   logic [23:0]        win_near  = '0;
   logic [23:0]        win_far   = '0;
   logic [24:0]        line_store [STORE_DEPTH];
   int                 store_fill = 0;

   pixel_type      pending_pixels [$];
   rsp_type        expected_blends [$];
   rsp_type        want;
   alpha_mode_type alpha_mode = ALPHA_ANY;

   int pixels_sent    = 0;
   int blends_checked = 0;
   int mismatches     = 0;
   int gap_pct        = 8;
   int stall_pct      = 8;

   rgba_overlay_yuv420_blend u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (cur_px.red),
      .req_green          (cur_px.green),
      .req_blue           (cur_px.blue),
      .req_alpha          (cur_px.alpha),
      .req_bg_luma        (cur_px.bg_luma),
      .req_bg_cb          (cur_px.bg_cb),
      .req_bg_cr          (cur_px.bg_cr),
      .req_start_of_frame (cur_px.sof),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_luma_out       (rsp_luma_out),
      .rsp_luma_write     (rsp_luma_write),
      .rsp_chroma_valid   (rsp_chroma_valid),
      .rsp_cb_out         (rsp_cb_out),
      .rsp_cr_out         (rsp_cr_out),
      .rsp_chroma_write   (rsp_chroma_write)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int clamp_width(logic [WIDTH_W-1:0] raw);
      int w;
      w = int'(raw) & ~1;
      if (w < 4) w = 4;
      else if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic logic [7:0] mix255(int fg, int a, int bg);
      return 8'((fg * a + bg * (255 - a)) / 255);
   endfunction

   // 1-2-1 over Cb, Cr and alpha; top bit flags any nonzero tap alpha
   function automatic logic [24:0] filter_taps(logic [23:0] l, logic [23:0] c,
                                               logic [23:0] r);
      logic [24:0] f;
      int s;
      for (int k = 0; k < 3; k++) begin
         s = int'(l[8*k +: 8]) + 2 * int'(c[8*k +: 8]) + int'(r[8*k +: 8]);
         f[8*k +: 8] = 8'(s >> 2);
      end
      f[24] = |(l[23:16] | c[23:16] | r[23:16]);
      return f;
   endfunction

   function automatic rsp_type blend_pixel(pixel_type px);
      rsp_type     res;
      int          w, col, idx, y, sb, sr, ucb, ucr, aa;
      logic [23:0] cur, left, right;
      logic [24:0] f, top;
      res = '0;
      w = clamp_width(width_reg);
      if (px.sof) begin
         col_pos = 0;
         row_odd = 1'b0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_odd = ~row_odd;
      end
      col = col_pos;

      if (px.alpha != 8'd0) begin
         y = ((66 * int'(px.red) + 129 * int'(px.green) + 25 * int'(px.blue) + 128) >> 8)
             + 16;
         res.luma_out   = mix255(y, int'(px.alpha), int'(px.bg_luma));
         res.luma_write = 1'b1;
      end else begin
         res.luma_out = px.bg_luma;
      end

      sb = 112 * int'(px.blue) + 32896 - 38 * int'(px.red) - 74 * int'(px.green);
      sr = 112 * int'(px.red) + 32896 - 94 * int'(px.green) - 18 * int'(px.blue);
      cur = {px.alpha, 8'(sr >> 8), 8'(sb >> 8)};

      if (col % 2 == 1) begin
         left  = (col == 1) ? win_near : win_far;
         right = (col == w - 1) ? win_near : cur;
         f = filter_taps(left, win_near, right);
         idx = col >> 1;
         if (!row_odd) begin
            line_store[idx] = f;
            if (idx + 1 > store_fill) store_fill = idx + 1;
         end else begin
            top = line_store[idx];
            res.chroma_valid = 1'b1;
            if (top[24] || f[24]) begin
               ucb = (int'(top[7:0]) + int'(f[7:0])) >> 1;
               ucr = (int'(top[15:8]) + int'(f[15:8])) >> 1;
               aa  = (int'(top[23:16]) + int'(f[23:16])) >> 1;
               res.cb_out       = mix255(ucb, aa, int'(px.bg_cb));
               res.cr_out       = mix255(ucr, aa, int'(px.bg_cr));
               res.chroma_write = 1'b1;
            end else begin
               res.cb_out = px.bg_cb;
               res.cr_out = px.bg_cr;
            end
         end
      end

      win_far  = win_near;
      win_near = cur;
      col_pos  = col + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_odd = ~row_odd;
      end
      return res;
   endfunction

   // Request driver; also tracks the width register and feeds the predictor
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         width_reg = WIDTH_RESET;
         col_pos   = 0;
         row_odd   = 1'b0;
         win_near  = '0;
         win_far   = '0;
      end else begin
         if (csr_wr_en) width_reg = csr_wr_data;
         if (req_valid && !req_stall) expected_blends.push_back(blend_pixel(cur_px));
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= gap_pct) begin
               cur_px    <= pending_pixels.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, int got, int exp_val);
      mismatches++;
      $display("mismatch on response %0d: %s = %0d, expected %0d",
               blends_checked, what, got, exp_val);
   endtask

   // Response monitor
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blends.size() == 0) begin
            report_mismatch("unexpected response, luma_out", rsp_luma_out, 0);
         end else begin
            want = expected_blends.pop_front();
            if (rsp_luma_out != want.luma_out)
               report_mismatch("luma_out", rsp_luma_out, want.luma_out);
            if (rsp_luma_write != want.luma_write)
               report_mismatch("luma_write", rsp_luma_write, want.luma_write);
            if (rsp_chroma_valid != want.chroma_valid)
               report_mismatch("chroma_valid", rsp_chroma_valid, want.chroma_valid);
            if (rsp_cb_out != want.cb_out)
               report_mismatch("cb_out", rsp_cb_out, want.cb_out);
            if (rsp_cr_out != want.cr_out)
               report_mismatch("cr_out", rsp_cr_out, want.cr_out);
            if (rsp_chroma_write != want.chroma_write)
               report_mismatch("chroma_write", rsp_chroma_write, want.chroma_write);
         end
         blends_checked++;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      // alpha runs in stretches so fully transparent blocks show up
      if ($urandom_range(15) == 0) alpha_mode = alpha_mode_type'($urandom_range(3));
      case (alpha_mode)
         ALPHA_CLEAR:  px.alpha = 8'd0;
         ALPHA_OPAQUE: px.alpha = 8'd255;
         ALPHA_SPARSE: px.alpha = ($urandom_range(3) == 0) ? pick_byte() : 8'd0;
         default:      px.alpha = pick_byte();
      endcase
      px.red     = pick_byte();
      px.green   = pick_byte();
      px.blue    = pick_byte();
      px.bg_luma = pick_byte();
      px.bg_cb   = pick_byte();
      px.bg_cr   = pick_byte();
      px.sof     = ($urandom_range(149) == 0);
      return px;
   endfunction

   function automatic void add_pixel(int r, int g, int b, int a, int y, int cb, int cr,
                                     bit sof);
      pending_pixels.push_back({8'(r), 8'(g), 8'(b), 8'(a), 8'(y), 8'(cb), 8'(cr), sof});
      pixels_sent++;
   endfunction

   task automatic wait_idle();
      while (blends_checked < pixels_sent) @(posedge clock);
   endtask

   // Drain, optionally rewrite the width, then queue random pixels
   task automatic run_phase(int raw, int count, bit sof_first);
      pixel_type px;
      wait_idle();
      if (raw >= 0) begin
         // an odd row must not reach line store entries no even row has filled
         if (row_odd && clamp_width(WIDTH_W'(raw)) / 2 > store_fill) sof_first = 1'b1;
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= WIDTH_W'(raw);
         @(posedge clock);
         csr_wr_en   <= 1'b0;
      end
      for (int i = 0; i < count; i++) begin
         px = random_pixel();
         if (i == 0 && sof_first) px.sof = 1'b1;
         pending_pixels.push_back(px);
         pixels_sent++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_phase(-1, 40, 1'b0);

      run_phase(4, 0, 1'b0);
      // even row, transparent
      add_pixel(255, 255, 255,   0,   0,   0,   0, 1'b1);
      add_pixel(  0,   0,   0,   0, 255, 255, 255, 1'b0);
      add_pixel(255,   0,   0,   0, 128,   0,   0, 1'b0);
      add_pixel(  0, 255,   0,   0,  17, 255, 255, 1'b0);
      // odd row, transparent: background chroma passes through
      add_pixel(  0,   0, 255,   0,  50, 255, 255, 1'b0);
      add_pixel(255, 255,   0,   0,  60,  11, 222, 1'b0);
      add_pixel( 12,  34,  56,   0, 255, 255, 255, 1'b0);
      add_pixel(255, 255, 255,   0,   0, 255,   0, 1'b0);
      // even row, opaque color extremes
      add_pixel(255, 255, 255, 255,   0,   0,   0, 1'b0);
      add_pixel(  0,   0,   0, 255, 255,   0,   0, 1'b0);
      add_pixel(255,   0,   0, 255,   0,   0,   0, 1'b0);
      add_pixel(  0, 255,   0, 255, 255,   0,   0, 1'b0);
      // odd row, opaque
      add_pixel(  0,   0, 255, 255,   0,   0,   0, 1'b0);
      add_pixel(255, 255,   0, 255, 255,   0, 255, 1'b0);
      add_pixel(  0, 255, 255, 255,   0,   0,   0, 1'b0);
      add_pixel(255,   0, 255, 255, 255, 255,   0, 1'b0);
      // even row, partial alpha
      add_pixel(200, 100,  50,   1, 255,   0,   0, 1'b0);
      add_pixel( 50, 100, 200, 128,   0,   0,   0, 1'b0);
      add_pixel(255, 255, 255, 254, 128,   0,   0, 1'b0);
      add_pixel(  0,   0,   0,   0,  77,   0,   0, 1'b0);
      // odd row mostly transparent under a partly opaque row
      add_pixel( 10,  20,  30,   0,   1,   0,   0, 1'b0);
      add_pixel( 40,  50,  60,   0,   2, 255, 255, 1'b0);
      add_pixel( 70,  80,  90,   0,   3,   0,   0, 1'b0);
      add_pixel( 99,  99,  99,   1,   4, 128, 128, 1'b0);

      run_phase(4, 200, 1'b0);
      run_phase(6, 150, 1'b0);
      run_phase(7, 100, 1'b0);
      run_phase(2, 80, 1'b0);
      run_phase(0, 60, 1'b0);
      run_phase(8, 120, 1'b0);
      run_phase(-1, 100, 1'b0);
      run_phase(4096, 150, 1'b1);
      // shrink mid-row: next pixel wraps to the following row
      run_phase(100, 150, 1'b0);
      run_phase(8191, 60, 1'b0);

      wait_idle();
      gap_pct   = 0;
      stall_pct = 0;
      run_phase(10, 200, 1'b0);
      wait_idle();
      gap_pct   = 8;
      stall_pct = 8;

      run_phase(1920, 60, 1'b0);
      run_phase(3, 80, 1'b0);
      run_phase(34, 150, 1'b0);
      run_phase(12, 150, 1'b0);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
